// ----- src/bfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Bilinear frame sampler package
// Shared widths, register indexes, action codes and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int DIM_W     = 11;  // frame_width / frame_height
  localparam int ADDR_W    = 18;  // pixel_address field
  localparam int COORD_W   = 16;  // norm_x / norm_y
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 23;  // y * width + x, wide enough for any size

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd240;

  localparam logic [7:0] BLACK_COLOR = 8'd0;
  localparam logic [7:0] BLACK_ALPHA = 8'd255;

  // Neighbor read order: 0 is (x0,y0), 1 is (x1,y0), 2 is (x0,y1), 3 is (x1,y1).
  typedef struct packed {
    logic       load;      // capture the accepted item
    logic       wr;        // store the pixel if it lies in the frame
    logic       map;       // scale coordinates to pixel space
    logic       place;     // wrap or clamp, find neighbors
    logic       row;       // row base addresses
    logic       rd_en;     // issue a frame store read
    logic [1:0] rd_sel;
    logic       cap_en;    // capture the read data of the previous cycle
    logic [1:0] cap_sel;
    logic       mix1;      // horizontal blend
    logic       mix2;      // vertical blend
    logic       out_load;  // load the result register
  } bfs_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic use_black;
  } bfs_stat_t;

endpackage

// ----- src/bfs_if.sv -----
// ----------------------------------------------------------------------------
// Bilinear frame sampler channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bfs_req_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [bfs_pkg::ADDR_W-1:0]     pixel_address;
  logic [7:0]                     red;
  logic [7:0]                     green;
  logic [7:0]                     blue;
  logic [7:0]                     alpha;
  logic signed [bfs_pkg::COORD_W-1:0] norm_x;
  logic signed [bfs_pkg::COORD_W-1:0] norm_y;
  logic                           wrap_mode;

  modport source (output valid, action, pixel_address, red, green, blue, alpha,
                  norm_x, norm_y, wrap_mode, input ready);
  modport sink (input valid, action, pixel_address, red, green, blue, alpha,
                norm_x, norm_y, wrap_mode, output ready);
endinterface

interface bfs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface bfs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bfs_pkg::CFG_IDX_W-1:0]    index;
  logic [bfs_pkg::DIM_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/bfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bilinear frame sampler controller
// Sequences one item at a time through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module bfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  bfs_pkg::bfs_stat_t stat,
  output bfs_pkg::bfs_cmd_t  cmd
);
  import bfs_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_PLACE  = 4'd2;
  localparam logic [3:0] ST_ROW    = 4'd3;
  localparam logic [3:0] ST_RD0    = 4'd4;
  localparam logic [3:0] ST_RD1    = 4'd5;
  localparam logic [3:0] ST_RD2    = 4'd6;
  localparam logic [3:0] ST_RD3    = 4'd7;
  localparam logic [3:0] ST_RD4    = 4'd8;
  localparam logic [3:0] ST_MIX1   = 4'd9;
  localparam logic [3:0] ST_MIX2   = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  logic [3:0] state, state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!stat.is_sample) begin
          cmd.wr     = 1'b1;
          state_next = ST_IDLE;
        end else if (stat.use_black) begin
          state_next = ST_DONE;
        end else begin
          cmd.map    = 1'b1;
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = ST_ROW;
      end
      ST_ROW: begin
        cmd.row    = 1'b1;
        state_next = ST_RD0;
      end
      ST_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd0;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = 2'd1;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd0;
        state_next  = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = 2'd2;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd1;
        state_next  = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = 2'd3;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd2;
        state_next  = ST_RD4;
      end
      ST_RD4: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd3;
        state_next  = ST_MIX1;
      end
      ST_MIX1: begin
        cmd.mix1   = 1'b1;
        state_next = ST_MIX2;
      end
      ST_MIX2: begin
        cmd.mix2   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // Hold here until the result register has room.
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/bfs_datapath.sv -----
// ----------------------------------------------------------------------------
// Bilinear frame sampler datapath
// Frame store, configuration registers, coordinate mapping and the blend.
// ----------------------------------------------------------------------------
module bfs_datapath #(
  parameter int MAX_PIXELS    = 262144,
  parameter int FRACTION_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bfs_pkg::bfs_cmd_t                  cmd,
  output bfs_pkg::bfs_stat_t                 stat,
  input  logic                               cfg_we,
  input  logic [bfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfs_pkg::DIM_W-1:0]          cfg_data,
  input  logic                               action,
  input  logic [bfs_pkg::ADDR_W-1:0]         pixel_address,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  input  logic [7:0]                         alpha,
  input  logic signed [bfs_pkg::COORD_W-1:0] norm_x,
  input  logic signed [bfs_pkg::COORD_W-1:0] norm_y,
  input  logic                               wrap_mode,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic [7:0]                         out_alpha
);
  import bfs_pkg::*;

  localparam int F     = FRACTION_BITS;
  localparam int SH    = 15 - F;
  localparam int AW    = $clog2(MAX_PIXELS);
  localparam int PW    = 30;             // mapped position, signed
  localparam int TW    = 9 + F;          // horizontal blend
  localparam int ACCW  = 10 + 2 * F;     // vertical blend
  localparam logic [ACCW-1:0] ROUND = ACCW'(1) << (2 * F - 1);

  logic [DIM_W-1:0]          frame_width, frame_height;
  logic                      loaded;
  logic                      action_q, wrap_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [31:0]               pix_q;
  logic signed [COORD_W-1:0] nx_q, ny_q;

  logic signed [28:0]        prod_x, prod_y;
  logic [DIM_W-1:0]          x0, x1, y0, y1;
  logic [F-1:0]              tx, ty;
  logic [21:0]               rb0, rb1;

  logic [31:0]               mem [MAX_PIXELS];
  logic [31:0]               rdata;
  logic                      oob_q;
  logic [31:0]               px [4];
  logic [TW-1:0]             top [4];
  logic [TW-1:0]             bot [4];
  logic [ACCW-1:0]           acc [4];

  logic [IDX_W-1:0]          waddr, ridx;
  logic [21:0]               frame_area;
  logic                      wr_ok;
  logic signed [PW-1:0]      fx_c, fy_c;
  logic [PW-1:0]             fxp, fyp;
  logic [DIM_W-1:0]          x0_c, y0_c;
  logic [F:0]                stx, sty;

  function automatic logic [PW-1:0] place_f(input logic signed [PW-1:0] f,
                                            input logic [DIM_W-1:0] size,
                                            input logic wrap);
    logic signed [PW-1:0] m;
    logic signed [PW-1:0] lim;
    m   = $signed(PW'({size, {F{1'b0}}}));
    lim = $signed(PW'({size - 11'd1, {F{1'b0}}}));
    // The mapped position stays within half a frame on either side.
    if (wrap) begin
      if (f < 0)       return f + m;
      else if (f >= m) return f - m;
      else             return f;
    end
    if (f < 0)   return '0;
    if (f > lim) return lim;
    return f;
  endfunction

  function automatic logic [DIM_W-1:0] next_f(input logic [DIM_W-1:0] c,
                                              input logic [DIM_W-1:0] size,
                                              input logic wrap);
    if (c == size - 11'd1) return wrap ? '0 : c;
    return c + 11'd1;
  endfunction

  assign stat.is_sample = (action_q == ACT_SAMPLE);
  assign stat.use_black = !loaded || (frame_width == '0) || (frame_height == '0);

  assign frame_area = 22'(frame_width) * 22'(frame_height);
  assign waddr      = IDX_W'(addr_q);
  assign wr_ok      = (waddr < IDX_W'(frame_area)) && (waddr < IDX_W'(MAX_PIXELS));

  assign fx_c = $signed({prod_x[28], prod_x}) >>> SH;
  assign fy_c = $signed({prod_y[28], prod_y}) >>> SH;
  assign fxp  = place_f(fx_c, frame_width, wrap_q);
  assign fyp  = place_f(fy_c, frame_height, wrap_q);
  assign x0_c = fxp[F+DIM_W-1:F];
  assign y0_c = fyp[F+DIM_W-1:F];

  assign ridx = IDX_W'(cmd.rd_sel[1] ? rb1 : rb0) + IDX_W'(cmd.rd_sel[0] ? x1 : x0);

  assign stx = {1'b1, {F{1'b0}}} - {1'b0, tx};
  assign sty = {1'b1, {F{1'b0}}} - {1'b0, ty};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      loaded       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.wr && wr_ok) begin
        loaded <= 1'b1;
      end
    end
  end

  // Single-port frame store; writes and reads never share a cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      mem[waddr[AW-1:0]] <= pix_q;
    end
    if (cmd.rd_en) begin
      rdata <= mem[ridx[AW-1:0]];
      oob_q <= (ridx >= IDX_W'(MAX_PIXELS));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action;
      wrap_q   <= wrap_mode;
      addr_q   <= pixel_address;
      pix_q    <= {alpha, blue, green, red};
      nx_q     <= norm_x;
      ny_q     <= norm_y;
    end
    if (cmd.map) begin
      prod_x <= ($signed({nx_q[15], nx_q}) + 17'sd16384)
                * $signed({1'b0, frame_width - 11'd1});
      prod_y <= (17'sd16384 - $signed({ny_q[15], ny_q}))
                * $signed({1'b0, frame_height - 11'd1});
    end
    if (cmd.place) begin
      x0 <= x0_c;
      y0 <= y0_c;
      x1 <= next_f(x0_c, frame_width, wrap_q);
      y1 <= next_f(y0_c, frame_height, wrap_q);
      tx <= fxp[F-1:0];
      ty <= fyp[F-1:0];
    end
    if (cmd.row) begin
      rb0 <= 22'(y0) * 22'(frame_width);
      rb1 <= 22'(y1) * 22'(frame_width);
    end
    if (cmd.cap_en) begin
      px[cmd.cap_sel] <= oob_q ? '0 : rdata;
    end
    for (int ch = 0; ch < 4; ch++) begin
      if (cmd.mix1) begin
        top[ch] <= TW'(px[0][8*ch +: 8]) * TW'(stx) + TW'(px[1][8*ch +: 8]) * TW'(tx);
        bot[ch] <= TW'(px[2][8*ch +: 8]) * TW'(stx) + TW'(px[3][8*ch +: 8]) * TW'(tx);
      end
      if (cmd.mix2) begin
        acc[ch] <= ACCW'(top[ch]) * ACCW'(sty) + ACCW'(bot[ch]) * ACCW'(ty);
      end
    end
  end

  function automatic logic [7:0] round_f(input logic [ACCW-1:0] a);
    logic [ACCW-1:0] v;
    v = (a + ROUND) >> (2 * F);
    return (v > ACCW'(255)) ? 8'd255 : v[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (stat.use_black) begin
        out_red   <= BLACK_COLOR;
        out_green <= BLACK_COLOR;
        out_blue  <= BLACK_COLOR;
        out_alpha <= BLACK_ALPHA;
      end else begin
        out_red   <= round_f(acc[0]);
        out_green <= round_f(acc[1]);
        out_blue  <= round_f(acc[2]);
        out_alpha <= round_f(acc[3]);
      end
    end
  end

endmodule

// ----- src/bilinear_frame_sampler.sv -----
// ----------------------------------------------------------------------------
// Bilinear frame sampler
// Stores an RGBA frame and answers bilinear sample requests against it.
// ----------------------------------------------------------------------------
// Channel | Role  | Carries
// req     | sink  | pixel writes and sample requests
// rsp     | source| one blended RGBA result per sample
// cfg     | sink  | frame_width (index 0), frame_height (index 1)
//
// A sample reads its four neighbors one after another through the single
// port of the frame store. A sample before any stored pixel skips the reads
// and returns opaque black. Reset sets the sizes to 320x240 and clears the
// loaded flag; the frame store is not cleared. A result waiting in the
// output register holds the next sample in its DONE state until taken.
// ----------------------------------------------------------------------------
module bilinear_frame_sampler #(
  parameter int MAX_PIXELS    = 262144,
  parameter int FRACTION_BITS = 8
) (
  input logic  clk,
  input logic  rst,
  bfs_req_if.sink   req,
  bfs_rsp_if.source rsp,
  bfs_cfg_if.sink   cfg
);
  import bfs_pkg::*;

  bfs_cmd_t  cmd;
  bfs_stat_t stat;

  assign cfg.ready = 1'b1;

  bfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfs_datapath #(
    .MAX_PIXELS    (MAX_PIXELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .action        (req.action),
    .pixel_address (req.pixel_address),
    .red           (req.red),
    .green         (req.green),
    .blue          (req.blue),
    .alpha         (req.alpha),
    .norm_x        (req.norm_x),
    .norm_y        (req.norm_y),
    .wrap_mode     (req.wrap_mode),
    .out_red       (rsp.out_red),
    .out_green     (rsp.out_green),
    .out_blue      (rsp.out_blue),
    .out_alpha     (rsp.out_alpha)
  );

endmodule

// ----- src/bfs_checker.sv -----
// ----------------------------------------------------------------------------
// Bilinear frame sampler checker
// Port-level properties of the sampler, attached by a bind statement.
// ----------------------------------------------------------------------------
module bfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_action,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);
  import bfs_pkg::*;

  logic [1:0] pending;
  logic       seen_write;
  logic       smp_acc, rsp_acc;

  assign smp_acc = req_valid && req_ready && (req_action == ACT_SAMPLE);
  assign rsp_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      seen_write <= 1'b0;
    end else begin
      pending <= pending + 2'(smp_acc) - 2'(rsp_acc);
      if (req_valid && req_ready && (req_action == ACT_WRITE)) begin
        seen_write <= 1'b1;
      end
    end
  end

  // Every result answers an earlier sample request.
  a_rsp_has_sample: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without an outstanding sample");

  // Before any pixel write the answer is opaque black.
  a_black_unloaded: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !seen_write) |->
      (out_red == BLACK_COLOR && out_green == BLACK_COLOR &&
       out_blue == BLACK_COLOR && out_alpha == BLACK_ALPHA))
    else $error("result before any write is not opaque black");

  // A stalled result keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable({out_red, out_green, out_blue, out_alpha})))
    else $error("stalled result changed");

endmodule

bind bilinear_frame_sampler bfs_checker u_bfs_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_action (req.action),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .out_red    (rsp.out_red),
  .out_green  (rsp.out_green),
  .out_blue   (rsp.out_blue),
  .out_alpha  (rsp.out_alpha)
);
